/* src/pld_pkg.sv */
`timescale 1ns / 1ps

package pld_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        CMD_GENERAL     = 2'd0,
        CMD_TWO_POINTS  = 2'd1,
        CMD_POINT_SLOPE = 2'd2
    } cmd_t;

endpackage

/* src/pld_front.sv */
`timescale 1ns / 1ps

module pld_front #(
    parameter int COORD_WIDTH = pld_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = pld_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              in_valid,
    input  logic [1:0]                        command,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     first_x,
    input  logic signed [COORD_WIDTH-1:0]     first_y,
    input  logic signed [COORD_WIDTH-1:0]     second_x,
    input  logic signed [COORD_WIDTH-1:0]     second_y,
    input  logic signed [COORD_WIDTH-1:0]     slope,
    input  logic signed [COORD_WIDTH-1:0]     coef_a,
    input  logic signed [COORD_WIDTH-1:0]     coef_b,
    input  logic signed [COORD_WIDTH-1:0]     coef_c,
    output logic                              out_valid,
    output logic                              degen,
    output logic [2*COORD_WIDTH+1:0]          d2,
    output logic                              dsat,
    output logic [2*COORD_WIDTH+1:0]          dr,
    output logic [2*COORD_WIDTH-1:0]          dn,
    output logic                              xsat,
    output logic                              xneg,
    output logic [2*COORD_WIDTH+1:0]          xr,
    output logic [COORD_WIDTH-1:0]            xn,
    output logic                              ysat,
    output logic                              yneg,
    output logic [2*COORD_WIDTH+1:0]          yr,
    output logic [COORD_WIDTH-1:0]            yn
);
    import pld_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int AW  = W + 1;
    localparam int CW  = 2 * W + 1;
    localparam int NW  = 2 * W + 3;
    localparam int DW  = 2 * W + 2;
    localparam int NNW = 2 * NW;
    localparam int PW  = 3 * W + 2;
    localparam int FW  = 3 * W + 4;
    localparam int PPW = 2 * W + 3;
    localparam int LW  = W + 2;
    localparam int HW  = NW - LW;

    // stage 1: line form to a, b and the product operands for c
    logic signed [W-1:0]    ma1, mb1, ma2, mb2;
    logic signed [AW-1:0]   a1_next, b1_next;
    logic signed [CW-1:0]   base1_next;
    logic signed [2*W-1:0]  m1_next, m2_next;
    logic signed [AW-1:0]   a1_reg, b1_reg;
    logic signed [2*W-1:0]  m1_reg, m2_reg;
    logic signed [CW-1:0]   base1_reg;
    logic signed [W-1:0]    px1_reg, py1_reg;
    logic                   v1_reg;

    always_comb begin
        ma1        = '0;
        mb1        = '0;
        ma2        = '0;
        mb2        = '0;
        a1_next    = AW'(coef_a);
        b1_next    = AW'(coef_b);
        base1_next = CW'(coef_c) <<< FRAC_BITS;
        unique case (cmd_t'(command))
            CMD_TWO_POINTS: begin
                a1_next    = AW'(second_y) - AW'(first_y);
                b1_next    = AW'(first_x) - AW'(second_x);
                base1_next = '0;
                ma1        = second_x;
                mb1        = first_y;
                ma2        = first_x;
                mb2        = second_y;
            end
            CMD_POINT_SLOPE: begin
                a1_next    = AW'(slope);
                b1_next    = AW'(0) - (AW'(1) <<< FRAC_BITS);
                base1_next = CW'(first_y) <<< FRAC_BITS;
                ma2        = slope;
                mb2        = first_x;
            end
            default: begin
                a1_next    = AW'(coef_a);
                b1_next    = AW'(coef_b);
                base1_next = CW'(coef_c) <<< FRAC_BITS;
            end
        endcase
        m1_next = ma1 * mb1;
        m2_next = ma2 * mb2;
    end

    // stage 2: c
    logic signed [AW-1:0]   a2_reg, b2_reg;
    logic signed [CW-1:0]   c2_reg;
    logic signed [W-1:0]    px2_reg, py2_reg;
    logic                   v2_reg;

    // stage 3: first products
    logic signed [AW+W-1:0] apx3_reg, bpy3_reg;
    logic signed [2*AW-1:0] aa3_reg, bb3_reg, ab3_reg;
    logic signed [AW-1:0]   a3_reg, b3_reg;
    logic signed [CW-1:0]   c3_reg;
    logic signed [W-1:0]    px3_reg, py3_reg;
    logic                   v3_reg;

    // stage 3 operands split into a signed high part and an unsigned low part
    logic signed [2*AW-W-1:0] aa3_hi, bb3_hi, ab3_hi;
    logic signed [W:0]        aa3_lo, bb3_lo, ab3_lo;
    logic signed [CW-W-1:0]   c3_hi;
    logic signed [W:0]        c3_lo;

    assign aa3_hi = aa3_reg[2*AW-1:W];
    assign bb3_hi = bb3_reg[2*AW-1:W];
    assign ab3_hi = ab3_reg[2*AW-1:W];
    assign aa3_lo = {1'b0, aa3_reg[W-1:0]};
    assign bb3_lo = {1'b0, bb3_reg[W-1:0]};
    assign ab3_lo = {1'b0, ab3_reg[W-1:0]};
    assign c3_hi  = c3_reg[CW-1:W];
    assign c3_lo  = {1'b0, c3_reg[W-1:0]};

    // stage 4: n, d2 and partial foot products
    logic signed [NW-1:0]   n4_reg;
    logic [DW-1:0]          d2_4_reg;
    logic signed [PPW-1:0]  bbpx_h4_reg, bbpx_l4_reg, abpy_h4_reg, abpy_l4_reg;
    logic signed [PPW-1:0]  ac_h4_reg, ac_l4_reg;
    logic signed [PPW-1:0]  aapy_h4_reg, aapy_l4_reg, abpx_h4_reg, abpx_l4_reg;
    logic signed [PPW-1:0]  bc_h4_reg, bc_l4_reg;
    logic                   v4_reg;

    // stage 5: foot products, partial n squared
    logic [NW-1:0]          nmag;
    logic signed [PW-1:0]   bbpx5_reg, abpy5_reg, ac5_reg;
    logic signed [PW-1:0]   aapy5_reg, abpx5_reg, bc5_reg;
    logic [2*HW-1:0]        nhh5_reg;
    logic [HW+LW-1:0]       nhl5_reg;
    logic [2*LW-1:0]        nll5_reg;
    logic [DW-1:0]          d2_5_reg;
    logic                   v5_reg;

    assign nmag = n4_reg[NW-1] ? NW'(-n4_reg) : NW'(n4_reg);

    // stage 6: n squared, foot numerators
    logic [NNW-1:0]         nn6_reg;
    logic [DW-1:0]          d2_6_reg;
    logic signed [FW-1:0]   xs6_reg, ys6_reg;
    logic                   v6_reg;

    // stage 7: divider setup and overflow checks
    logic [NNW-2*W-1:0]     nn_hi;
    logic [FW-1:0]          xmag, ymag;
    logic [FW-W-1:0]        x_hi, y_hi;
    logic                   dsat_next, xsat_next, ysat_next;
    logic                   v7_reg;

    always_comb begin
        nn_hi     = nn6_reg[NNW-1:2*W];
        dsat_next = nn_hi >= (NNW-2*W)'(d2_6_reg);
        xmag      = xs6_reg[FW-1] ? FW'(-xs6_reg) : FW'(xs6_reg);
        ymag      = ys6_reg[FW-1] ? FW'(-ys6_reg) : FW'(ys6_reg);
        x_hi      = xmag[FW-1:W];
        y_hi      = ymag[FW-1:W];
        xsat_next = x_hi >= (FW-W)'(d2_6_reg);
        ysat_next = y_hi >= (FW-W)'(d2_6_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            m1_reg    <= m1_next;
            m2_reg    <= m2_next;
            base1_reg <= base1_next;
            px1_reg   <= point_x;
            py1_reg   <= point_y;

            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            c2_reg  <= base1_reg + CW'(m1_reg) - CW'(m2_reg);
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;

            apx3_reg <= a2_reg * px2_reg;
            bpy3_reg <= b2_reg * py2_reg;
            aa3_reg  <= a2_reg * a2_reg;
            bb3_reg  <= b2_reg * b2_reg;
            ab3_reg  <= a2_reg * b2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;

            n4_reg      <= NW'(apx3_reg) + NW'(bpy3_reg) + NW'(c3_reg);
            d2_4_reg    <= DW'(aa3_reg + bb3_reg);
            bbpx_h4_reg <= bb3_hi * px3_reg;
            bbpx_l4_reg <= bb3_lo * px3_reg;
            abpy_h4_reg <= ab3_hi * py3_reg;
            abpy_l4_reg <= ab3_lo * py3_reg;
            ac_h4_reg   <= a3_reg * c3_hi;
            ac_l4_reg   <= a3_reg * c3_lo;
            aapy_h4_reg <= aa3_hi * py3_reg;
            aapy_l4_reg <= aa3_lo * py3_reg;
            abpx_h4_reg <= ab3_hi * px3_reg;
            abpx_l4_reg <= ab3_lo * px3_reg;
            bc_h4_reg   <= b3_reg * c3_hi;
            bc_l4_reg   <= b3_reg * c3_lo;

            bbpx5_reg <= (PW'(bbpx_h4_reg) <<< W) + PW'(bbpx_l4_reg);
            abpy5_reg <= (PW'(abpy_h4_reg) <<< W) + PW'(abpy_l4_reg);
            ac5_reg   <= (PW'(ac_h4_reg) <<< W) + PW'(ac_l4_reg);
            aapy5_reg <= (PW'(aapy_h4_reg) <<< W) + PW'(aapy_l4_reg);
            abpx5_reg <= (PW'(abpx_h4_reg) <<< W) + PW'(abpx_l4_reg);
            bc5_reg   <= (PW'(bc_h4_reg) <<< W) + PW'(bc_l4_reg);
            nhh5_reg  <= nmag[NW-1:LW] * nmag[NW-1:LW];
            nhl5_reg  <= nmag[NW-1:LW] * nmag[LW-1:0];
            nll5_reg  <= nmag[LW-1:0] * nmag[LW-1:0];
            d2_5_reg  <= d2_4_reg;

            nn6_reg  <= (NNW'(nhh5_reg) << (2 * LW)) + (NNW'(nhl5_reg) << (LW + 1))
                        + NNW'(nll5_reg);
            d2_6_reg <= d2_5_reg;
            xs6_reg  <= FW'(bbpx5_reg) - FW'(abpy5_reg) - FW'(ac5_reg);
            ys6_reg  <= FW'(aapy5_reg) - FW'(abpx5_reg) - FW'(bc5_reg);

            degen <= d2_6_reg == '0;
            d2    <= d2_6_reg;
            dsat  <= dsat_next;
            dr    <= dsat_next ? '0 : nn_hi[DW-1:0];
            dn    <= nn6_reg[2*W-1:0];
            xsat  <= xsat_next;
            xneg  <= xs6_reg[FW-1];
            xr    <= xsat_next ? '0 : x_hi[DW-1:0];
            xn    <= xmag[W-1:0];
            ysat  <= ysat_next;
            yneg  <= ys6_reg[FW-1];
            yr    <= ysat_next ? '0 : y_hi[DW-1:0];
            yn    <= ymag[W-1:0];
        end
    end

    assign out_valid = v7_reg;

endmodule

/* src/pld_cell.sv */
`timescale 1ns / 1ps

module pld_cell #(
    parameter int COORD_WIDTH = 32,
    parameter bit DO_DIST     = 1'b0,
    parameter bit DO_FOOT     = 1'b0,
    parameter bit DO_SQRT     = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic                          in_degen,
    input  logic [2*COORD_WIDTH+1:0]      in_d2,
    input  logic                          in_dsat,
    input  logic [2*COORD_WIDTH+1:0]      in_dr,
    input  logic [2*COORD_WIDTH-1:0]      in_dn,
    input  logic [2*COORD_WIDTH-1:0]      in_dq,
    input  logic                          in_xsat,
    input  logic                          in_xneg,
    input  logic [2*COORD_WIDTH+1:0]      in_xr,
    input  logic [COORD_WIDTH-1:0]        in_xn,
    input  logic [COORD_WIDTH-1:0]        in_xq,
    input  logic                          in_ysat,
    input  logic                          in_yneg,
    input  logic [2*COORD_WIDTH+1:0]      in_yr,
    input  logic [COORD_WIDTH-1:0]        in_yn,
    input  logic [COORD_WIDTH-1:0]        in_yq,
    input  logic [COORD_WIDTH:0]          in_sr,
    input  logic [COORD_WIDTH-1:0]        in_root,
    output logic                          out_valid,
    output logic                          out_degen,
    output logic [2*COORD_WIDTH+1:0]      out_d2,
    output logic                          out_dsat,
    output logic [2*COORD_WIDTH+1:0]      out_dr,
    output logic [2*COORD_WIDTH-1:0]      out_dn,
    output logic [2*COORD_WIDTH-1:0]      out_dq,
    output logic                          out_xsat,
    output logic                          out_xneg,
    output logic [2*COORD_WIDTH+1:0]      out_xr,
    output logic [COORD_WIDTH-1:0]        out_xn,
    output logic [COORD_WIDTH-1:0]        out_xq,
    output logic                          out_ysat,
    output logic                          out_yneg,
    output logic [2*COORD_WIDTH+1:0]      out_yr,
    output logic [COORD_WIDTH-1:0]        out_yn,
    output logic [COORD_WIDTH-1:0]       out_yq,
    output logic [COORD_WIDTH:0]          out_sr,
    output logic [COORD_WIDTH-1:0]        out_root
);
    import pld_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = 2 * W + 2;
    localparam int SRW = W + 1;

    logic [DW:0]             dt, xt, yt, dd;
    logic                    dge, xge, yge, sge;
    logic [SRW+1:0]          st, trial;
    logic [DW-1:0]           dr_next, xr_next, yr_next;
    logic [2*W-1:0]          dn_next, dq_next;
    logic [W-1:0]            xn_next, xq_next, yn_next, yq_next, root_next;
    logic [SRW-1:0]          sr_next;

    always_comb begin
        dd        = {1'b0, in_d2};
        dt        = {in_dr, in_dn[2*W-1]};
        xt        = {in_xr, in_xn[W-1]};
        yt        = {in_yr, in_yn[W-1]};
        dge       = dt >= dd;
        xge       = xt >= dd;
        yge       = yt >= dd;
        st        = {in_sr, in_dq[2*W-1:2*W-2]};
        trial     = (SRW+2)'({in_root, 2'b01});
        sge       = st >= trial;

        dr_next   = in_dr;
        dn_next   = in_dn;
        dq_next   = in_dq;
        xr_next   = in_xr;
        xn_next   = in_xn;
        xq_next   = in_xq;
        yr_next   = in_yr;
        yn_next   = in_yn;
        yq_next   = in_yq;
        sr_next   = in_sr;
        root_next = in_root;

        // one restoring quotient bit of n*n / d2
        if (DO_DIST) begin
            dr_next = dge ? DW'(dt - dd) : DW'(dt);
            dn_next = in_dn << 1;
            dq_next = {in_dq[2*W-2:0], dge};
        end
        // one quotient bit of each foot coordinate
        if (DO_FOOT) begin
            xr_next = xge ? DW'(xt - dd) : DW'(xt);
            xn_next = in_xn << 1;
            xq_next = {in_xq[W-2:0], xge};
            yr_next = yge ? DW'(yt - dd) : DW'(yt);
            yn_next = in_yn << 1;
            yq_next = {in_yq[W-2:0], yge};
        end
        // one root bit, two radicand bits a step
        if (DO_SQRT) begin
            sr_next   = sge ? SRW'(st - trial) : SRW'(st);
            dq_next   = in_dq << 2;
            root_next = {in_root[W-2:0], sge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (ce) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_degen <= in_degen;
            out_d2    <= in_d2;
            out_dsat  <= in_dsat;
            out_dr    <= dr_next;
            out_dn    <= dn_next;
            out_dq    <= dq_next;
            out_xsat  <= in_xsat;
            out_xneg  <= in_xneg;
            out_xr    <= xr_next;
            out_xn    <= xn_next;
            out_xq    <= xq_next;
            out_ysat  <= in_ysat;
            out_yneg  <= in_yneg;
            out_yr    <= yr_next;
            out_yn    <= yn_next;
            out_yq    <= yq_next;
            out_sr    <= sr_next;
            out_root  <= root_next;
        end
    end

endmodule

/* src/point_line_distance_and_foot.sv */
`timescale 1ns / 1ps

// channel  | ports                                              | direction
// ---------+----------------------------------------------------+----------
// query    | s_valid s_ready s_command s_point_* s_first_*      | in
//          | s_second_* s_slope s_coef_a s_coef_b s_coef_c     |
// result   | m_valid m_ready m_distance m_foot_x m_foot_y       | out
//          | m_degenerate                                       |
//
// one beat per cycle while no result beat waits on m_ready; the pipeline is
// seven setup stages, 2*COORD_WIDTH divider cells, COORD_WIDTH root cells,
// output register. the whole chain holds while a result beat waits on m_ready.
// synchronous active-low reset clears the valid bits only.

module point_line_distance_and_foot #(
    parameter int COORD_WIDTH = pld_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = pld_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic signed [COORD_WIDTH-1:0] s_point_x,
    input  logic signed [COORD_WIDTH-1:0] s_point_y,
    input  logic signed [COORD_WIDTH-1:0] s_first_x,
    input  logic signed [COORD_WIDTH-1:0] s_first_y,
    input  logic signed [COORD_WIDTH-1:0] s_second_x,
    input  logic signed [COORD_WIDTH-1:0] s_second_y,
    input  logic signed [COORD_WIDTH-1:0] s_slope,
    input  logic signed [COORD_WIDTH-1:0] s_coef_a,
    input  logic signed [COORD_WIDTH-1:0] s_coef_b,
    input  logic signed [COORD_WIDTH-1:0] s_coef_c,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_WIDTH-1:0]        m_distance,
    output logic signed [COORD_WIDTH-1:0] m_foot_x,
    output logic signed [COORD_WIDTH-1:0] m_foot_y,
    output logic                          m_degenerate
);
    import pld_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = 2 * W + 2;
    localparam int SRW = W + 1;
    localparam int NC  = 3 * W;

    logic ce;

    logic           c_valid [0:NC];
    logic           c_degen [0:NC];
    logic [DW-1:0]  c_d2    [0:NC];
    logic           c_dsat  [0:NC];
    logic [DW-1:0]  c_dr    [0:NC];
    logic [2*W-1:0] c_dn    [0:NC];
    logic [2*W-1:0] c_dq    [0:NC];
    logic           c_xsat  [0:NC];
    logic           c_xneg  [0:NC];
    logic [DW-1:0]  c_xr    [0:NC];
    logic [W-1:0]   c_xn    [0:NC];
    logic [W-1:0]   c_xq    [0:NC];
    logic           c_ysat  [0:NC];
    logic           c_yneg  [0:NC];
    logic [DW-1:0]  c_yr    [0:NC];
    logic [W-1:0]   c_yn    [0:NC];
    logic [W-1:0]   c_yq    [0:NC];
    logic [SRW-1:0] c_sr    [0:NC];
    logic [W-1:0]   c_root  [0:NC];

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    pld_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .command   (s_command),
        .point_x   (s_point_x),
        .point_y   (s_point_y),
        .first_x   (s_first_x),
        .first_y   (s_first_y),
        .second_x  (s_second_x),
        .second_y  (s_second_y),
        .slope     (s_slope),
        .coef_a    (s_coef_a),
        .coef_b    (s_coef_b),
        .coef_c    (s_coef_c),
        .out_valid (c_valid[0]),
        .degen     (c_degen[0]),
        .d2        (c_d2[0]),
        .dsat      (c_dsat[0]),
        .dr        (c_dr[0]),
        .dn        (c_dn[0]),
        .xsat      (c_xsat[0]),
        .xneg      (c_xneg[0]),
        .xr        (c_xr[0]),
        .xn        (c_xn[0]),
        .ysat      (c_ysat[0]),
        .yneg      (c_yneg[0]),
        .yr        (c_yr[0]),
        .yn        (c_yn[0])
    );

    assign c_dq[0]   = '0;
    assign c_xq[0]   = '0;
    assign c_yq[0]   = '0;
    assign c_sr[0]   = '0;
    assign c_root[0] = '0;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        pld_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .DO_DIST     (i < 2 * W),
            .DO_FOOT     (i >= W && i < 2 * W),
            .DO_SQRT     (i >= 2 * W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (c_valid[i]),
            .in_degen  (c_degen[i]),
            .in_d2     (c_d2[i]),
            .in_dsat   (c_dsat[i]),
            .in_dr     (c_dr[i]),
            .in_dn     (c_dn[i]),
            .in_dq     (c_dq[i]),
            .in_xsat   (c_xsat[i]),
            .in_xneg   (c_xneg[i]),
            .in_xr     (c_xr[i]),
            .in_xn     (c_xn[i]),
            .in_xq     (c_xq[i]),
            .in_ysat   (c_ysat[i]),
            .in_yneg   (c_yneg[i]),
            .in_yr     (c_yr[i]),
            .in_yn     (c_yn[i]),
            .in_yq     (c_yq[i]),
            .in_sr     (c_sr[i]),
            .in_root   (c_root[i]),
            .out_valid (c_valid[i+1]),
            .out_degen (c_degen[i+1]),
            .out_d2    (c_d2[i+1]),
            .out_dsat  (c_dsat[i+1]),
            .out_dr    (c_dr[i+1]),
            .out_dn    (c_dn[i+1]),
            .out_dq    (c_dq[i+1]),
            .out_xsat  (c_xsat[i+1]),
            .out_xneg  (c_xneg[i+1]),
            .out_xr    (c_xr[i+1]),
            .out_xn    (c_xn[i+1]),
            .out_xq    (c_xq[i+1]),
            .out_ysat  (c_ysat[i+1]),
            .out_yneg  (c_yneg[i+1]),
            .out_yr    (c_yr[i+1]),
            .out_yn    (c_yn[i+1]),
            .out_yq    (c_yq[i+1]),
            .out_sr    (c_sr[i+1]),
            .out_root  (c_root[i+1])
        );
    end

    // saturation and sign of the final beat
    logic [W-1:0] half, smin, smax;
    logic [W-1:0] dist_next, fx_next, fy_next;

    always_comb begin
        half = W'(1) << (W - 1);
        smin = half;
        smax = half - W'(1);

        if (c_degen[NC]) begin
            dist_next = '0;
        end else if (c_dsat[NC]) begin
            dist_next = '1;
        end else begin
            dist_next = c_root[NC];
        end

        if (c_degen[NC]) begin
            fx_next = '0;
        end else if (c_xsat[NC]) begin
            fx_next = c_xneg[NC] ? smin : smax;
        end else if (c_xneg[NC]) begin
            fx_next = (c_xq[NC] > half) ? smin : W'(0) - c_xq[NC];
        end else begin
            fx_next = (c_xq[NC] >= half) ? smax : c_xq[NC];
        end

        if (c_degen[NC]) begin
            fy_next = '0;
        end else if (c_ysat[NC]) begin
            fy_next = c_yneg[NC] ? smin : smax;
        end else if (c_yneg[NC]) begin
            fy_next = (c_yq[NC] > half) ? smin : W'(0) - c_yq[NC];
        end else begin
            fy_next = (c_yq[NC] >= half) ? smax : c_yq[NC];
        end
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= c_valid[NC];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_distance   <= dist_next;
            m_foot_x     <= fx_next;
            m_foot_y     <= fy_next;
            m_degenerate <= c_degen[NC];
        end
    end

    assign m_valid = m_valid_reg;

endmodule
